FILE: hdl/cpta_pkg.sv
// Shared types, constants and codes of the capacity pool target allocator.
`default_nettype none
package cpta_pkg;

   // Table depth and field widths
   localparam int TARGETS  = 1024;
   localparam int MAX_PICK = 64;
   localparam int ID_W     = 10;
   localparam int CNT_W    = $clog2(TARGETS + 1);
   localparam int PICK_W   = 7;

   // Command codes
   localparam logic [2:0] CMD_ADD_OR_MOVE   = 3'd0;
   localparam logic [2:0] CMD_ADD_IF_ABSENT = 3'd1;
   localparam logic [2:0] CMD_REMOVE        = 3'd2;
   localparam logic [2:0] CMD_QUERY         = 3'd3;
   localparam logic [2:0] CMD_CHOOSE        = 3'd4;

   // Pool selects and query pool codes
   localparam logic [1:0] POOL_NORMAL    = 2'd0;
   localparam logic [1:0] POOL_LOW       = 2'd1;
   localparam logic [1:0] POOL_EMERGENCY = 2'd2;
   localparam logic [1:0] POOL_INVALID   = 2'd3;

   // Membership codes held in the table
   localparam logic [1:0] MEMB_NONE      = 2'd0;
   localparam logic [1:0] MEMB_NORMAL    = 2'd1;
   localparam logic [1:0] MEMB_LOW       = 2'd2;
   localparam logic [1:0] MEMB_EMERGENCY = 2'd3;

   typedef struct packed {
      logic [2:0]        command;
      logic [ID_W-1:0]   target_id;
      logic [1:0]        pool_select;
      logic [PICK_W-1:0] target_count;
   } req_type;

   typedef struct packed {
      logic            flag;
      logic [1:0]      pool_code;
      logic [ID_W-1:0] chosen_target;
      logic            target_valid;
      logic            last_of_run;
   } rsp_type;

   // Sequencer to scanner
   typedef struct packed {
      logic            load;
      logic            run;
      logic [ID_W-1:0] addr;
      logic [1:0]      code;
   } scan_ctl_type;

   // Scanner to sequencer
   typedef struct packed {
      logic            hit;
      logic [ID_W-1:0] addr;
   } scan_sts_type;

   function automatic logic [ID_W-1:0] ring_inc(input logic [ID_W-1:0] a);
      logic [ID_W-1:0] r;
      if (a == ID_W'(TARGETS - 1)) r = '0;
      else r = a + ID_W'(1);
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/capacity_pool_target_allocator.sv
// Top level of the tiered-pool target allocator: sequencer, pool counts, result register.
// Add, move, remove, query: entry read at acceptance, rewritten the next cycle if changed;
//   word via EXEC and rsp register, busy high for 1 cycle; next command once idle again.
// Choose: the scanner checks one entry a cycle between hits; EXEC decodes and loads it at
//   the last pick, FIND seeks the start member, PICK gives one word per next member.
// Reset: synchronous; a clearing pass over all 1024 entries empties the table, busy high. No stall.
`default_nettype none
module capacity_pool_target_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cpta_pkg::req_type req_word,
   output logic                   rsp_valid,
   output cpta_pkg::rsp_type      rsp_word
);
   import cpta_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_FIND  = 5'b01000,
      ST_PICK  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [ID_W-1:0]   clr_ff, clr_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  size0_ff, size1_ff, size2_ff;
   logic [CNT_W-1:0]  size0_in, size1_in, size2_in;
   logic [ID_W-1:0]   last_pick_ff, last_pick_in;
   logic [PICK_W-1:0] rem_ff, rem_in;
   logic [1:0]        code_ff, code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // table and scanner hookup
   logic              wr_en;
   logic [ID_W-1:0]   wr_addr;
   logic [1:0]        wr_data;
   logic [ID_W-1:0]   rd_addr;
   logic [ID_W-1:0]   scan_rd_addr;
   logic [1:0]        mem_q;
   scan_ctl_type      scan_ctl;
   scan_sts_type      scan_sts;

   // EXEC helpers
   logic              in_table;
   logic [1:0]        cur;
   logic [1:0]        new_code;
   logic              upd;
   logic [1:0]        sel_code;
   logic [CNT_W-1:0]  sel_size;
   logic [CNT_W-1:0]  n_cnt;
   logic [CNT_W-1:0]  n_lim;

   cpta_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   cpta_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (mem_q),
      .rd_addr (scan_rd_addr),
      .sts     (scan_sts)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // IDs past the table count as absent from every pool
   assign in_table = (32'(req_ff.target_id) < TARGETS);
   assign cur      = in_table ? mem_q : MEMB_NONE;
   assign new_code = req_ff.pool_select + 2'd1;

   // first non-empty pool, normal before low before emergency
   always_comb begin
      priority if (size0_ff != '0) begin
         sel_code = MEMB_NORMAL;
         sel_size = size0_ff;
      end else if (size1_ff != '0) begin
         sel_code = MEMB_LOW;
         sel_size = size1_ff;
      end else begin
         sel_code = MEMB_EMERGENCY;
         sel_size = size2_ff;
      end
      // clamp the request to the pool size and to the pick limit
      n_cnt = (CNT_W'(req_ff.target_count) < sel_size) ? CNT_W'(req_ff.target_count)
                                                       : sel_size;
      n_lim = (n_cnt > CNT_W'(MAX_PICK)) ? CNT_W'(MAX_PICK) : n_cnt;
   end

   // decide whether the current command rewrites the table entry
   always_comb begin
      upd = 1'b0;
      unique case (req_ff.command)
         CMD_ADD_OR_MOVE:
            upd = in_table && (req_ff.pool_select != POOL_INVALID) && (cur != new_code);
         CMD_ADD_IF_ABSENT:
            upd = in_table && (req_ff.pool_select != POOL_INVALID) && (cur == MEMB_NONE);
         CMD_REMOVE:
            upd = in_table && (cur != MEMB_NONE);
         default:
            upd = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      size0_in     = size0_ff;
      size1_in     = size1_ff;
      size2_in     = size2_ff;
      last_pick_in = last_pick_ff;
      rem_in       = rem_ff;
      code_in      = code_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = req_ff.target_id;
      wr_data      = MEMB_NONE;
      rd_addr      = scan_rd_addr;
      scan_ctl     = '0;
      scan_ctl.code = code_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the table to "no pool", one entry a cycle
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + ID_W'(1);
            if (clr_ff == ID_W'(TARGETS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            // read the addressed entry right away
            rd_addr = req_word.target_id;
            if (start) begin
               req_in   = req_word;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            rsp_in.last_of_run = 1'b1;
            state_in           = ST_IDLE;
            if (req_ff.command == CMD_CHOOSE) begin
               if (sel_size == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  // start the scan at the stored last pick
                  rem_in        = PICK_W'(n_lim);
                  code_in       = sel_code;
                  scan_ctl.load = 1'b1;
                  scan_ctl.addr = last_pick_ff;
                  state_in      = ST_FIND;
               end
            end else begin
               rsp_valid_in = 1'b1;
               if (req_ff.command == CMD_QUERY) begin
                  if (cur != MEMB_NONE) begin
                     rsp_in.flag      = 1'b1;
                     rsp_in.pool_code = cur - 2'd1;
                  end else begin
                     rsp_in.pool_code = POOL_EMERGENCY;
                  end
               end
               if (upd) begin
                  wr_en   = 1'b1;
                  wr_data = (req_ff.command == CMD_REMOVE) ? MEMB_NONE : new_code;
                  rsp_in.flag = (req_ff.command != CMD_REMOVE);
                  // move the count from the old pool to the new one
                  size0_in = size0_ff - CNT_W'(cur == MEMB_NORMAL)
                                      + CNT_W'(wr_data == MEMB_NORMAL);
                  size1_in = size1_ff - CNT_W'(cur == MEMB_LOW)
                                      + CNT_W'(wr_data == MEMB_LOW);
                  size2_in = size2_ff - CNT_W'(cur == MEMB_EMERGENCY)
                                      + CNT_W'(wr_data == MEMB_EMERGENCY);
               end
            end
         end

         ST_FIND: begin
            scan_ctl.run = 1'b1;
            if (scan_sts.hit) begin
               if (rem_ff == '0) begin
                  // nothing asked for: still advance the ring start
                  last_pick_in       = scan_sts.addr;
                  rsp_valid_in       = 1'b1;
                  rsp_in.last_of_run = 1'b1;
                  state_in           = ST_IDLE;
               end else begin
                  state_in = ST_PICK;
               end
            end
         end

         ST_PICK: begin
            scan_ctl.run = 1'b1;
            if (scan_sts.hit) begin
               rsp_valid_in         = 1'b1;
               rsp_in.chosen_target = scan_sts.addr;
               rsp_in.target_valid  = 1'b1;
               rsp_in.last_of_run   = (rem_ff == PICK_W'(1));
               last_pick_in         = scan_sts.addr;
               rem_in               = rem_ff - PICK_W'(1);
               if (rem_ff == PICK_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         size0_ff     <= '0;
         size1_ff     <= '0;
         size2_ff     <= '0;
         last_pick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         size0_ff     <= size0_in;
         size1_ff     <= size1_in;
         size2_ff     <= size2_in;
         last_pick_ff <= last_pick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rem_ff  <= rem_in;
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire

FILE: hdl/cpta_table.sv
// Membership table: one write port, one registered read port.
`default_nettype none
module cpta_table (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [cpta_pkg::ID_W-1:0] wr_addr,
   input  wire logic [1:0]               wr_data,
   input  wire logic [cpta_pkg::ID_W-1:0] rd_addr,
   output logic      [1:0]               rd_data
);
   import cpta_pkg::*;

   logic [1:0] mem [TARGETS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hdl/cpta_scan.sv
// Circular scanner: streams table addresses and finds the next member of a pool.
`default_nettype none
module cpta_scan (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cpta_pkg::scan_ctl_type    ctl,
   input  wire logic [1:0]                rd_data,
   output logic      [cpta_pkg::ID_W-1:0] rd_addr,
   output cpta_pkg::scan_sts_type         sts
);
   import cpta_pkg::*;

   logic [ID_W-1:0] scan_addr_ff, scan_addr_in;
   logic [ID_W-1:0] chk_addr_ff;
   logic            chk_vld_ff, chk_vld_in;
   logic            hit;

   // Data for chk_addr_ff arrives in the cycle after its address went out
   assign hit      = ctl.run && chk_vld_ff && (rd_data == ctl.code);
   assign rd_addr  = scan_addr_ff;
   assign sts.hit  = hit;
   assign sts.addr = chk_addr_ff;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      chk_vld_in   = 1'b0;
      priority if (ctl.load) begin
         scan_addr_in = ctl.addr;
      end else if (hit) begin
         // restart after the hit; drop the read already in flight
         scan_addr_in = ring_inc(chk_addr_ff);
      end else if (ctl.run) begin
         scan_addr_in = ring_inc(scan_addr_ff);
         chk_vld_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      chk_addr_ff  <= scan_addr_ff;
   end

endmodule
`default_nettype wire

FILE: hdl/cpta_checker.sv
// Port-level checks of the allocator and their binding to the top level.
`default_nettype none
module cpta_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire cpta_pkg::req_type req,
   input wire logic              rsp_valid,
   input wire cpta_pkg::rsp_type rsp
);
   import cpta_pkg::*;

   // a word only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without preceding work");

   // an accepted command locks out the next one
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a command");

   // single-word commands answer with a final word after the EXEC state and the result register
   a_single_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.command != CMD_CHOOSE)) |=> ##1 (rsp_valid && rsp.last_of_run))
      else $error("single-word command did not answer on time");

   // a word without a pick always closes its run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.target_valid) |-> rsp.last_of_run)
      else $error("word without pick does not end the run");

   // after the final word the block is free again
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.last_of_run) |-> !busy)
      else $error("block still busy after final word");

endmodule

bind capacity_pool_target_allocator cpta_checker u_cpta_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req_word),
   .rsp_valid (rsp_valid),
   .rsp       (rsp_word)
);
`default_nettype wire
